// ===== hw/rtl/rsst_pkg.sv =====
// Package for the range-sum segment tree: sizes, microcode step codes and the control ROM.
`default_nettype none

package rsst_pkg;

	// Tree geometry. Leaf i lives at node LEAVES+i; node 1 is the root.
	localparam int LEAVES = 1024;
	localparam int NODES  = 2 * LEAVES;
	localparam int IDX_W  = 10;                // width of a leaf index field
	localparam int NODE_W = $clog2(NODES);     // width of a node address
	localparam int BE_W   = NODE_W + 1;        // range walk bounds reach NODES
	localparam int DATA_W = 64;

	// Stream payload layout of the input tdata, lowest bit first.
	localparam int POS_LSB   = 0;
	localparam int VAL_LSB   = POS_LSB + IDX_W;
	localparam int RB_LSB    = VAL_LSB + DATA_W;
	localparam int RE_LSB    = RB_LSB + IDX_W;
	localparam int IN_BITS   = RE_LSB + IDX_W;
	localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	// Opcode carried in tuser.
	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Microcode step addresses.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_CLR   = 4'd0;
	localparam logic [STEP_W-1:0] ST_IDLE  = 4'd1;
	localparam logic [STEP_W-1:0] ST_DISP  = 4'd2;
	localparam logic [STEP_W-1:0] ST_ULEAF = 4'd3;
	localparam logic [STEP_W-1:0] ST_URD   = 4'd4;
	localparam logic [STEP_W-1:0] ST_UWR   = 4'd5;
	localparam logic [STEP_W-1:0] ST_QINIT = 4'd6;
	localparam logic [STEP_W-1:0] ST_QRD   = 4'd7;
	localparam logic [STEP_W-1:0] ST_QACC  = 4'd8;
	localparam logic [STEP_W-1:0] ST_QOUT  = 4'd9;

	// Jump conditions.
	localparam logic [2:0] C_NEVER        = 3'd0;
	localparam logic [2:0] C_ALWAYS       = 3'd1;
	localparam logic [2:0] C_NO_ITEM      = 3'd2;
	localparam logic [2:0] C_QUERY        = 3'd3;
	localparam logic [2:0] C_K_NZ         = 3'd4;
	localparam logic [2:0] C_K_ABOVE_ROOT = 3'd5;
	localparam logic [2:0] C_B_GE_E       = 3'd6;
	localparam logic [2:0] C_OUT_BUSY     = 3'd7;

	// Node pointer operations.
	localparam logic [1:0] K_HOLD = 2'd0;
	localparam logic [1:0] K_LOAD = 2'd1;
	localparam logic [1:0] K_HALF = 2'd2;
	localparam logic [1:0] K_DEC  = 2'd3;

	// Write data selection.
	localparam logic [1:0] WD_ZERO = 2'd0;
	localparam logic [1:0] WD_LEAF = 2'd1;
	localparam logic [1:0] WD_SUM  = 2'd2;

	typedef struct packed {
		logic              in_rdy;
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic [1:0]        k_op;
		logic              rd_kids;
		logic              rd_ends;
		logic              q_init;
		logic              q_acc;
		logic              out_ld;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
		logic [STEP_W-1:0] nxt;
	} uword_t;

	// Control ROM: when cond holds the sequencer jumps to target, else it goes to nxt.
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w        = '0;
		w.cond   = C_ALWAYS;
		w.target = ST_IDLE;
		w.nxt    = ST_IDLE;
		unique case (step)
			ST_CLR: begin
				w.wr_en  = 1'b1;
				w.wr_sel = WD_ZERO;
				w.k_op   = K_DEC;
				w.cond   = C_K_NZ;
				w.target = ST_CLR;
				w.nxt    = ST_IDLE;
			end
			ST_IDLE: begin
				w.in_rdy = 1'b1;
				w.cond   = C_NO_ITEM;
				w.target = ST_IDLE;
				w.nxt    = ST_DISP;
			end
			ST_DISP: begin
				w.k_op   = K_LOAD;
				w.cond   = C_QUERY;
				w.target = ST_QINIT;
				w.nxt    = ST_ULEAF;
			end
			ST_ULEAF: begin
				w.wr_en  = 1'b1;
				w.wr_sel = WD_LEAF;
				w.k_op   = K_HALF;
				w.cond   = C_NEVER;
				w.nxt    = ST_URD;
			end
			ST_URD: begin
				w.rd_kids = 1'b1;
				w.cond    = C_NEVER;
				w.nxt     = ST_UWR;
			end
			ST_UWR: begin
				w.wr_en  = 1'b1;
				w.wr_sel = WD_SUM;
				w.k_op   = K_HALF;
				w.cond   = C_K_ABOVE_ROOT;
				w.target = ST_URD;
				w.nxt    = ST_IDLE;
			end
			ST_QINIT: begin
				w.q_init = 1'b1;
				w.cond   = C_NEVER;
				w.nxt    = ST_QRD;
			end
			ST_QRD: begin
				w.rd_ends = 1'b1;
				w.cond    = C_B_GE_E;
				w.target  = ST_QOUT;
				w.nxt     = ST_QACC;
			end
			ST_QACC: begin
				w.q_acc  = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = ST_QRD;
			end
			ST_QOUT: begin
				w.out_ld = 1'b1;
				w.cond   = C_OUT_BUSY;
				w.target = ST_QOUT;
				w.nxt    = ST_IDLE;
			end
			default: ;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/range_sum_segment_tree.sv =====
// Top level of the range-sum segment tree: microcoded sequencer, node memory and datapath.
`default_nettype none

// The block keeps 1024 signed 64-bit leaves in a bottom-up segment tree whose
// internal nodes hold the wrapping sums of their two children.
// Input transactions arrive on the s_ group: tuser is the opcode (0 sets a
// leaf, 1 asks for an inclusive range sum) and tdata carries the position,
// new value and range bounds. A set produces no output; a query produces one
// output transaction on the m_ group with the 64-bit wrapping sum in tdata.
// An empty range, including one that starts beyond the last leaf, gives zero.
// The work is done on the single node memory, which does one write and
// two reads per cycle, walked by a small microcode program. A set writes
// the leaf and then, before s_tready returns, reads the two children and
// writes their sum for each of the ten ancestor levels. A query loads its
// bounds, then alternates a read of the two bound nodes with an accumulate
// step, climbing one level each time (at most 11) until the bounds meet.
// After reset deasserts, a clearing pass writes zero to all 2048 nodes, one
// per cycle, and s_tready stays low until the pass ends.
// The result sits in an output register, so the block accepts and works on
// the next transaction while a result waits; only a second query that
// finishes while the first result is still stalled holds in its final step.
module range_sum_segment_tree (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// position[9:0], new_value[73:10], range_begin[83:74], range_end[93:84], zero fill
	input  wire logic [rsst_pkg::S_TDATA_W-1:0]   s_tdata,
	// opcode
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// range_sum[63:0]
	output logic [rsst_pkg::DATA_W-1:0]           m_tdata
);

	localparam int NODE_W = rsst_pkg::NODE_W;
	localparam int BE_W   = rsst_pkg::BE_W;
	localparam int IDX_W  = rsst_pkg::IDX_W;
	localparam int DATA_W = rsst_pkg::DATA_W;

	// Sequencer state.
	logic [rsst_pkg::STEP_W-1:0] step_q;
	logic [rsst_pkg::STEP_W-1:0] step_next;
	rsst_pkg::uword_t            uw;
	logic                        cond_true;

	// Captured transaction.
	logic              op_q;
	logic [IDX_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  rb_q;
	logic [IDX_W-1:0]  re_q;

	// Datapath.
	logic [NODE_W-1:0] k_q;
	logic [BE_W-1:0]   b_q;
	logic [BE_W-1:0]   e_q;
	logic [BE_W-1:0]   e_m1;
	logic [DATA_W-1:0] left_q;
	logic [DATA_W-1:0] right_q;
	logic [DATA_W-1:0] rd0_q;
	logic [DATA_W-1:0] rd1_q;
	logic [DATA_W-1:0] wdata;
	logic [NODE_W-1:0] ra0;
	logic [NODE_W-1:0] ra1;
	logic              rd_en;
	logic              accept;
	logic              out_busy;

	// Query bound preparation.
	logic [BE_W-1:0]   rb_w;
	logic [BE_W-1:0]   re_w;
	logic [BE_W-1:0]   last_sat;
	logic              q_empty;

	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;

	logic [DATA_W-1:0] node_mem [rsst_pkg::NODES];

	assign uw       = rsst_pkg::ucode(step_q);
	assign s_tready = uw.in_rdy;
	assign accept   = s_tvalid && s_tready;
	assign out_busy = m_tvalid_q && !m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Jump condition decode.
	always_comb begin
		unique case (uw.cond)
			rsst_pkg::C_NEVER:        cond_true = 1'b0;
			rsst_pkg::C_ALWAYS:       cond_true = 1'b1;
			rsst_pkg::C_NO_ITEM:      cond_true = !accept;
			rsst_pkg::C_QUERY:        cond_true = (op_q == rsst_pkg::OP_QUERY);
			rsst_pkg::C_K_NZ:         cond_true = (k_q != '0);
			rsst_pkg::C_K_ABOVE_ROOT: cond_true = (k_q > NODE_W'(1));
			rsst_pkg::C_B_GE_E:       cond_true = (b_q >= e_q);
			rsst_pkg::C_OUT_BUSY:     cond_true = out_busy;
			default:                  cond_true = 1'b0;
		endcase
		step_next = cond_true ? uw.target : uw.nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= rsst_pkg::ST_CLR;
		end else begin
			step_q <= step_next;
		end
	end

	// Transaction capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			pos_q <= s_tdata[rsst_pkg::POS_LSB +: IDX_W];
			val_q <= s_tdata[rsst_pkg::VAL_LSB +: DATA_W];
			rb_q  <= s_tdata[rsst_pkg::RB_LSB +: IDX_W];
			re_q  <= s_tdata[rsst_pkg::RE_LSB +: IDX_W];
		end
	end

	// Node pointer: clearing sweep counter and update walk position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= NODE_W'(rsst_pkg::NODES - 1);
		end else begin
			case (uw.k_op)
				rsst_pkg::K_LOAD: k_q <= NODE_W'(pos_q) + NODE_W'(rsst_pkg::LEAVES);
				rsst_pkg::K_HALF: k_q <= k_q >> 1;
				rsst_pkg::K_DEC:  k_q <= k_q - NODE_W'(1);
				default:          k_q <= k_q;
			endcase
		end
	end

	// Memory port addresses and write data.
	assign e_m1  = e_q - BE_W'(1);
	assign ra0   = uw.rd_kids ? {k_q[NODE_W-2:0], 1'b0} : b_q[NODE_W-1:0];
	assign ra1   = uw.rd_kids ? {k_q[NODE_W-2:0], 1'b1} : e_m1[NODE_W-1:0];
	assign rd_en = uw.rd_kids || uw.rd_ends;

	always_comb begin
		case (uw.wr_sel)
			rsst_pkg::WD_LEAF: wdata = val_q;
			rsst_pkg::WD_SUM:  wdata = rd0_q + rd1_q;
			default:           wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (uw.wr_en) begin
			node_mem[k_q] <= wdata;
		end
		if (rd_en) begin
			rd0_q <= node_mem[ra0];
			rd1_q <= node_mem[ra1];
		end
	end

	// Query bounds: the end is clamped to the last leaf, and an empty range
	// starts with equal bounds so the walk ends at once with a zero sum.
	assign rb_w     = BE_W'(rb_q);
	assign re_w     = BE_W'(re_q);
	assign last_sat = (re_w >= BE_W'(rsst_pkg::LEAVES)) ? BE_W'(rsst_pkg::LEAVES - 1) : re_w;
	assign q_empty  = (rb_w >= BE_W'(rsst_pkg::LEAVES)) || (rb_w > last_sat);

	always_ff @(posedge clk) begin
		if (uw.q_init) begin
			left_q  <= '0;
			right_q <= '0;
			if (q_empty) begin
				b_q <= '0;
				e_q <= '0;
			end else begin
				b_q <= rb_w + BE_W'(rsst_pkg::LEAVES);
				e_q <= last_sat + BE_W'(rsst_pkg::LEAVES + 1);
			end
		end else if (uw.q_acc) begin
			// An odd left bound takes its node and steps right; an odd right
			// bound takes the node below it and steps left.
			if (b_q[0]) begin
				left_q <= left_q + rd0_q;
			end
			if (e_q[0]) begin
				right_q <= rd1_q + right_q;
			end
			b_q <= (b_q + BE_W'(b_q[0])) >> 1;
			e_q <= (e_q - BE_W'(e_q[0])) >> 1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (uw.out_ld && !out_busy) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.out_ld && !out_busy) begin
			m_tdata_q <= left_q + right_q;
		end
	end

endmodule

`default_nettype wire
